>>> rtl/sdrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrt_pkg: split datagram reassembly table shared definitions
// table sizing, slot index constants, beat payload types and result codes
// ----------------------------------------------------------------------------
package sdrt_pkg;

  // table geometry
  localparam int TOTAL_SLOTS = 1024;
  localparam int NUM_ROWS    = 4;
  localparam int ROW_SIZE    = TOTAL_SLOTS / NUM_ROWS;
  localparam int ROW_W       = 2;
  localparam int COL_W       = (ROW_SIZE > 1) ? $clog2(ROW_SIZE) : 1;
  localparam int CNT_W       = $clog2(ROW_SIZE + 1);

  // field widths
  localparam int ID_W     = 16;
  localparam int HANDLE_W = 16;
  localparam int LENGTH_W = 16;
  localparam int DROP_W   = 32;
  localparam int HELD_W   = 11;

  // slot key is id >> 2; quotient by ROW_SIZE via reciprocal multiply
  localparam int KEY_W    = ID_W - 2;
  localparam int DIV_SH   = KEY_W + $clog2(ROW_SIZE);
  localparam int RECIP_W  = KEY_W + 2;
  localparam int RECIP    = ((1 << DIV_SH) + ROW_SIZE - 1) / ROW_SIZE;
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP);
  localparam logic [KEY_W-1:0]   ROW_MULT   = KEY_W'(ROW_SIZE);

  // the row cleared is this far ahead of the row written
  localparam logic [ROW_W-1:0] CLEAR_AHEAD = ROW_W'(2);
  localparam logic [ROW_W-1:0] CLEAR_RESET = ROW_W'(3);

  typedef enum logic [1:0] {
    OUT_STORED  = 2'd0,
    OUT_PAIRED  = 2'd1,
    OUT_DROPPED = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [ID_W-1:0]     datagram_id;
    logic [HANDLE_W-1:0] payload_handle;
    logic [LENGTH_W-1:0] payload_length;
  } item_t;

  typedef struct packed {
    outcome_t            outcome;
    logic [HANDLE_W-1:0] first_handle;
    logic [LENGTH_W-1:0] first_length;
    logic [HANDLE_W-1:0] second_handle;
    logic [LENGTH_W-1:0] second_length;
    logic [DROP_W-1:0]   dropped_total;
    logic [HELD_W-1:0]   held_total;
  } result_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } slot_addr_t;

  typedef struct packed {
    logic                is_first;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
  } slot_entry_t;

endpackage

>>> rtl/sdrt_slot_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrt_slot_map: slot key to row and column
// splits id >> 2 into a row (quotient mod 4) and a column (remainder)
// ----------------------------------------------------------------------------
module sdrt_slot_map (
  input  logic                      clk,
  input  logic                      load,
  input  logic [sdrt_pkg::KEY_W-1:0] key,
  output sdrt_pkg::slot_addr_t      addr
);

  logic [sdrt_pkg::KEY_W-1:0]                    key_q;
  logic [sdrt_pkg::KEY_W-1:0]                    quot;
  logic [sdrt_pkg::KEY_W+sdrt_pkg::RECIP_W-1:0]  recip_prod;
  logic [2*sdrt_pkg::KEY_W-1:0]                  base_prod;
  logic [sdrt_pkg::KEY_W-1:0]                    rem;

  // quotient by reciprocal multiply, exact for every key value
  assign recip_prod = key * sdrt_pkg::RECIP_MULT;

  always_ff @(posedge clk) begin
    if (load) begin
      key_q <= key;
      quot  <= sdrt_pkg::KEY_W'(recip_prod >> sdrt_pkg::DIV_SH);
    end
  end

  assign base_prod = quot * sdrt_pkg::ROW_MULT;
  assign rem       = key_q - base_prod[sdrt_pkg::KEY_W-1:0];

  assign addr.row = quot[sdrt_pkg::ROW_W-1:0];
  assign addr.col = rem[sdrt_pkg::COL_W-1:0];

endmodule

>>> rtl/split_datagram_reassembly_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_datagram_reassembly_table_top: pairs the two halves of split datagrams
// slot lookup, store or pair or test drop, row rotation clear, held counts
// ----------------------------------------------------------------------------
// Each item beat makes a single read-then-write pass over the slot memories:
// the accept cycle (slot quotient is registered), a read cycle (valid row
// word and slot entry are read from the synchronous memories) and an update
// cycle (the result is formed, the row word is written back unless the beat
// is dropped and the entry only on a store). The update cycle waits while a
// previous result beat is still held by result_stall. The next item beat is
// accepted as soon as the update is done, even while its result waits in the
// output register. Slot valid bits live in a 4 x ROW_SIZE memory, one word
// per row, so a row flash-clear is a single flag; no clearing pass is needed
// after reset. The drop test register may be written at any time the block
// is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module split_datagram_reassembly_table_top (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              item_valid,
  output logic              item_stall,
  input  sdrt_pkg::item_t   item,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output sdrt_pkg::result_t result,
  // drop test register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  state_t state;

  // configuration
  logic drop_test_enable;

  // held item
  logic                          hold_second;
  logic [sdrt_pkg::HANDLE_W-1:0] hold_handle;
  logic [sdrt_pkg::LENGTH_W-1:0] hold_length;

  // slot address from the divider
  sdrt_pkg::slot_addr_t addr;
  logic                 item_accept;

  // memories: one valid word per row, one entry per slot
  logic [sdrt_pkg::ROW_SIZE-1:0] valid_mem [sdrt_pkg::NUM_ROWS];
  sdrt_pkg::slot_entry_t
    entry_mem [sdrt_pkg::NUM_ROWS * (2 ** sdrt_pkg::COL_W)];
  logic [sdrt_pkg::ROW_SIZE-1:0] valid_rd;
  sdrt_pkg::slot_entry_t         entry_rd;

  // row bookkeeping
  logic [sdrt_pkg::NUM_ROWS-1:0]                      row_zero;
  logic [sdrt_pkg::NUM_ROWS-1:0]                      row_zero_next;
  logic [sdrt_pkg::NUM_ROWS-1:0][sdrt_pkg::CNT_W-1:0] row_count;
  logic [sdrt_pkg::NUM_ROWS-1:0][sdrt_pkg::CNT_W-1:0] row_count_next;
  logic [sdrt_pkg::ROW_W-1:0]                         last_wiped;
  logic [sdrt_pkg::DROP_W-1:0]                        drop_count;
  logic [sdrt_pkg::DROP_W-1:0]                        drop_count_next;

  // update cycle decode
  logic                          upd_go;
  logic [sdrt_pkg::ROW_SIZE-1:0] row_live;
  logic [sdrt_pkg::ROW_SIZE-1:0] col_bit;
  logic [sdrt_pkg::ROW_SIZE-1:0] valid_wr;
  logic                          hit;
  logic                          do_drop;
  logic                          do_pair;
  logic                          do_store;
  logic                          valid_we;
  logic [sdrt_pkg::ROW_W-1:0]    wipe_row;
  logic                          do_clear;
  logic [sdrt_pkg::CNT_W+1:0]    held_sum;
  sdrt_pkg::slot_entry_t         entry_wr;
  sdrt_pkg::result_t             result_next;

  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_test_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      drop_test_enable <= cfg_data;
    end
  end

  // quotient is registered at accept, row and column settle in the read cycle
  sdrt_slot_map u_slot_map (
    .clk  (clk),
    .load (item_accept),
    .key  (item.datagram_id[sdrt_pkg::ID_W-1:2]),
    .addr (addr)
  );

  always_ff @(posedge clk) begin
    if (item_accept) begin
      hold_second <= item.datagram_id[0];
      hold_handle <= item.payload_handle;
      hold_length <= item.payload_length;
    end
  end

  // memory reads in the read cycle; addr holds until the next accept
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      valid_rd <= valid_mem[addr.row];
      entry_rd <= entry_mem[{addr.row, addr.col}];
    end
  end

  // update when the output register is free or being emptied
  assign upd_go = (state == ST_UPDATE) && (!result_valid || !result_stall);

  // a row flagged as flash-cleared reads as all empty
  assign row_live = valid_rd & {sdrt_pkg::ROW_SIZE{!row_zero[addr.row]}};
  assign col_bit  = sdrt_pkg::ROW_SIZE'(1) << addr.col;
  assign hit      = row_live[addr.col];
  assign do_drop  = hit && drop_test_enable;
  assign do_pair  = hit && !drop_test_enable;
  assign do_store = !hit;

  assign valid_we = upd_go && !do_drop;
  assign valid_wr = do_pair ? (row_live & ~col_bit) : (row_live | col_bit);

  assign entry_wr.is_first = !hold_second;
  assign entry_wr.handle   = hold_handle;
  assign entry_wr.length   = hold_length;

  always_ff @(posedge clk) begin
    if (valid_we) begin
      valid_mem[addr.row] <= valid_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go && do_store) begin
      entry_mem[{addr.row, addr.col}] <= entry_wr;
    end
  end

  // rotation clear: the row two ahead, only when it is next in turn
  assign wipe_row = addr.row + sdrt_pkg::CLEAR_AHEAD;
  assign do_clear = do_store &&
                    (wipe_row == sdrt_pkg::ROW_W'(last_wiped + 1'b1));

  always_comb begin
    row_count_next  = row_count;
    drop_count_next = drop_count;
    row_zero_next   = row_zero;
    if (do_drop) begin
      drop_count_next = drop_count + 1'b1;
    end
    if (do_pair && (row_count[addr.row] != '0)) begin
      row_count_next[addr.row] = row_count[addr.row] - 1'b1;
    end
    if (do_store) begin
      row_count_next[addr.row] = row_count[addr.row] + 1'b1;
    end
    // a written row word is clean again
    if (!do_drop) begin
      row_zero_next[addr.row] = 1'b0;
    end
    if (do_clear) begin
      row_count_next[wipe_row] = '0;
      row_zero_next[wipe_row]  = 1'b1;
    end
  end

  assign held_sum = (sdrt_pkg::CNT_W+2)'(row_count_next[0]) +
                    (sdrt_pkg::CNT_W+2)'(row_count_next[1]) +
                    (sdrt_pkg::CNT_W+2)'(row_count_next[2]) +
                    (sdrt_pkg::CNT_W+2)'(row_count_next[3]);

  always_comb begin
    result_next               = '0;
    result_next.dropped_total = drop_count_next;
    result_next.held_total    = sdrt_pkg::HELD_W'(held_sum);
    priority if (do_drop) begin
      result_next.outcome = sdrt_pkg::OUT_DROPPED;
    end else if (do_pair) begin
      result_next.outcome = sdrt_pkg::OUT_PAIRED;
      if (entry_rd.is_first) begin
        result_next.first_handle  = entry_rd.handle;
        result_next.first_length  = entry_rd.length;
        result_next.second_handle = hold_handle;
        result_next.second_length = hold_length;
      end else begin
        result_next.first_handle  = hold_handle;
        result_next.first_length  = hold_length;
        result_next.second_handle = entry_rd.handle;
        result_next.second_length = entry_rd.length;
      end
    end else begin
      result_next.outcome = sdrt_pkg::OUT_STORED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      row_zero     <= '1;
      row_count    <= '0;
      last_wiped   <= sdrt_pkg::CLEAR_RESET;
      drop_count   <= '0;
    end else begin
      // a new result beat loads as the old one leaves
      if (upd_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_accept) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (upd_go) begin
            state      <= ST_IDLE;
            result     <= result_next;
            row_count  <= row_count_next;
            drop_count <= drop_count_next;
            row_zero   <= row_zero_next;
            if (do_clear) begin
              last_wiped <= wipe_row;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // only a paired beat carries descriptors
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.outcome != sdrt_pkg::OUT_PAIRED)) |->
      (result.first_handle == '0 && result.first_length == '0 &&
       result.second_handle == '0 && result.second_length == '0))
    else $error("descriptor fields set on an unpaired result");

  // a held count never exceeds the slots of its row
  assert property (@(posedge clk) disable iff (rst)
    (row_count[0] <= sdrt_pkg::CNT_W'(sdrt_pkg::ROW_SIZE)) &&
    (row_count[1] <= sdrt_pkg::CNT_W'(sdrt_pkg::ROW_SIZE)) &&
    (row_count[2] <= sdrt_pkg::CNT_W'(sdrt_pkg::ROW_SIZE)) &&
    (row_count[3] <= sdrt_pkg::CNT_W'(sdrt_pkg::ROW_SIZE)))
    else $error("row held count above row size");

  // drop counter moves only under drop test
  assert property (@(posedge clk) disable iff (rst)
    !drop_test_enable |=> $stable(drop_count))
    else $error("drop counter changed with drop test off");

  // counts change only in the update cycle
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_UPDATE) |=> $stable(row_count))
    else $error("row count changed outside update");

endmodule

>>> dv/tb_split_datagram_reassembly_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_split_datagram_reassembly_table_top: split datagram pairing testbench
// directed table then random half pairs and noise, checked beat by beat
// against an in-bench model of the slot table, row rotation and counters
// ----------------------------------------------------------------------------
module tb_split_datagram_reassembly_table_top;
  import sdrt_pkg::*;

  localparam int USED_SLOTS    = NUM_ROWS * ROW_SIZE;
  localparam int KEY_SPAN      = (1 << KEY_W) / USED_SLOTS;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 20;
  localparam int OPEN_MAX      = 8;
  localparam int NUM_DIRECTED  = 16;
  localparam int NUM_PHASES    = 6;
  localparam longint TIMEOUT_NS = 2_000_000;

  typedef struct {
    bit      drop;
    item_t   beat;
    bit      typed;
    result_t res;
  } directed_row_t;

  typedef struct {
    int unsigned sender_idle;
    int unsigned receiver_stall;
    bit          drop;
    int unsigned items;
  } phase_t;

  localparam result_t UNTYPED = '0;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic    cfg_data;

  // model of the table
  bit              slot_full   [USED_SLOTS];
  bit              slot_first  [USED_SLOTS];
  logic [15:0]     slot_handle [USED_SLOTS];
  logic [15:0]     slot_length [USED_SLOTS];
  int unsigned     row_held    [NUM_ROWS];
  logic [ROW_W-1:0] last_wiped = CLEAR_RESET;
  logic [DROP_W-1:0] drops = '0;
  bit              drop_mode = 1'b0;

  result_t     reassembly_results [$];
  item_t       open_halves [$];
  int unsigned mismatches = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_given = 0;

  // extremes, both pairing orders, rotation clears and drop mode
  directed_row_t directed [NUM_DIRECTED] = '{
    '{1'b0, '{16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{OUT_STORED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 11'd1}},
    '{1'b0, '{16'h0001, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{OUT_PAIRED, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 32'd0, 11'd0}},
    // second half arrives first
    '{1'b0, '{16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1,
      '{OUT_STORED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 11'd1}},
    '{1'b0, '{16'hFFFC, 16'h1234, 16'hABCD}, 1'b1,
      '{OUT_PAIRED, 16'h1234, 16'hABCD, 16'hFFFF, 16'h0000, 32'd0, 11'd0}},
    // row 2 store clears row 0
    '{1'b0, '{16'h0800, 16'h0001, 16'h0002}, 1'b1,
      '{OUT_STORED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 11'd1}},
    '{1'b0, '{16'h0004, 16'h0005, 16'h0006}, 1'b1,
      '{OUT_STORED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 11'd2}},
    '{1'b0, '{16'h0C00, 16'h0007, 16'h0008}, 1'b1,
      '{OUT_STORED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 11'd3}},
    // row 0 store wipes the occupied row 2
    '{1'b0, '{16'h0008, 16'h00FF, 16'hFF00}, 1'b1,
      '{OUT_STORED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 11'd3}},
    '{1'b0, '{16'h0801, 16'h8000, 16'h0001}, 1'b1,
      '{OUT_STORED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 11'd4}},
    '{1'b1, '{16'h0005, 16'h4321, 16'h8765}, 1'b1,
      '{OUT_DROPPED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd1, 11'd4}},
    '{1'b1, '{16'h0005, 16'h0000, 16'hFFFF}, 1'b1,
      '{OUT_DROPPED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd2, 11'd4}},
    '{1'b1, '{16'h0010, 16'h7FFF, 16'h8000}, 1'b1,
      '{OUT_STORED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd2, 11'd5}},
    '{1'b0, '{16'h0004, 16'h0009, 16'h000A}, 1'b1,
      '{OUT_PAIRED, 16'h0005, 16'h0006, 16'h0009, 16'h000A, 32'd2, 11'd4}},
    '{1'b0, '{16'h0400, 16'h0B0B, 16'h0C0C}, 1'b1,
      '{OUT_STORED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd2, 11'd4}},
    // high id bits alias onto the same slot
    '{1'b0, '{16'hF002, 16'hAAAA, 16'h5555}, 1'b0, UNTYPED},
    '{1'b0, '{16'h0003, 16'h5555, 16'hAAAA}, 1'b0, UNTYPED}
  };

  phase_t phases [NUM_PHASES] = '{
    '{0,  0,  1'b0, 250},
    '{70, 0,  1'b1, 100},
    '{0,  70, 1'b0, 250},
    '{16, 16, 1'b0, 200},
    '{0,  0,  1'b1, 50},
    '{16, 16, 1'b0, 150}
  };

  split_datagram_reassembly_table_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // one table step: store, pair or drop, then the rotation clear
  function automatic result_t reassemble(item_t it);
    int unsigned slot;
    int unsigned row;
    int unsigned wipe_row;
    int unsigned total;
    result_t     r;
    r = '0;
    r.outcome = OUT_STORED;
    slot = (int'(it.datagram_id) >> 2) % USED_SLOTS;
    row  = slot / ROW_SIZE;
    if (slot_full[slot]) begin
      if (drop_mode) begin
        drops++;
        r.outcome = OUT_DROPPED;
      end else begin
        if (slot_first[slot]) begin
          r.first_handle  = slot_handle[slot];
          r.first_length  = slot_length[slot];
          r.second_handle = it.payload_handle;
          r.second_length = it.payload_length;
        end else begin
          r.first_handle  = it.payload_handle;
          r.first_length  = it.payload_length;
          r.second_handle = slot_handle[slot];
          r.second_length = slot_length[slot];
        end
        slot_full[slot] = 1'b0;
        if (row_held[row] != 0) row_held[row]--;
        r.outcome = OUT_PAIRED;
      end
    end else begin
      wipe_row = (row + 2) % NUM_ROWS;
      slot_full[slot]   = 1'b1;
      slot_first[slot]  = !it.datagram_id[0];
      slot_handle[slot] = it.payload_handle;
      slot_length[slot] = it.payload_length;
      row_held[row]++;
      if (wipe_row == (int'(last_wiped) + 1) % NUM_ROWS) begin
        for (int c = 0; c < ROW_SIZE; c++) slot_full[wipe_row * ROW_SIZE + c] = 1'b0;
        row_held[wipe_row] = 0;
        last_wiped = ROW_W'(wipe_row);
      end
    end
    total = row_held[0] + row_held[1] + row_held[2] + row_held[3];
    r.dropped_total = drops;
    r.held_total    = HELD_W'(total);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // result beats against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (reassembly_results.size() == 0) begin
        $error("result beat with nothing outstanding: 0x%0h", result);
        mismatches++;
      end else begin
        want = reassembly_results[0];
        reassembly_results.delete(0);
        check_field("outcome", 32'(want.outcome), 32'(result.outcome));
        check_field("first_handle", 32'(want.first_handle), 32'(result.first_handle));
        check_field("first_length", 32'(want.first_length), 32'(result.first_length));
        check_field("second_handle", 32'(want.second_handle), 32'(result.second_handle));
        check_field("second_length", 32'(want.second_length), 32'(result.second_length));
        check_field("dropped_total", 32'(want.dropped_total), 32'(result.dropped_total));
        check_field("held_total", 32'(want.held_total), 32'(result.held_total));
      end
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_given) begin
        holds_given++;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  task automatic send_item(item_t it, bit typed, result_t typed_res);
    result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    r = reassemble(it);
    reassembly_results.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (reassembly_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_drop_test(bit v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    drop_mode = v;
  endtask

  initial begin
    item_t       it;
    item_t       partner;
    int unsigned k;
    int unsigned row;
    int unsigned col;
    int unsigned b0;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].drop != drop_mode) set_drop_test(directed[i].drop);
      send_item(directed[i].beat, directed[i].typed, directed[i].res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_drop_test(phases[p].drop);
      sender_idle_pct    = phases[p].sender_idle;
      receiver_stall_pct = phases[p].receiver_stall;
      // long output hold-off while items keep coming, so the input backs up
      if (p == 0) holds_asked++;
      for (int n = 0; n < phases[p].items; n++) begin
        // in phase 3 the sender waits for every outstanding result mid-phase
        if (p == 3 && n == phases[p].items / 2) begin
          item_valid <= 1'b0;
          while (reassembly_results.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        if (open_halves.size() != 0 &&
            ($urandom_range(1) == 1 || open_halves.size() >= OPEN_MAX)) begin
          k  = $urandom_range(open_halves.size() - 1);
          it = open_halves[k];
          open_halves.delete(k);
        end else if ($urandom_range(9) < 8) begin
          // new datagram; a few columns get most of the traffic so slots collide
          row = $urandom_range(NUM_ROWS - 1);
          col = $urandom_range(1) ? $urandom_range(3) : $urandom_range(ROW_SIZE - 1);
          b0  = $urandom_range(1);
          it.datagram_id = ID_W'((($urandom_range(KEY_SPAN - 1) * USED_SLOTS
                                   + row * ROW_SIZE + col) << 2)
                                 | ($urandom_range(1) << 1) | b0);
          it.payload_handle = HANDLE_W'($urandom);
          it.payload_length = LENGTH_W'($urandom);
          partner = it;
          partner.datagram_id[ID_W-1:ID_W-4] = 4'($urandom);
          partner.datagram_id[1] = 1'($urandom);
          partner.datagram_id[0] = !b0;
          partner.payload_handle = HANDLE_W'($urandom);
          partner.payload_length = LENGTH_W'($urandom);
          open_halves.push_back(partner);
        end else begin
          it = item_t'({$urandom, $urandom});
        end
        send_item(it, 1'b0, UNTYPED);
      end
    end

    item_valid <= 1'b0;
    while (reassembly_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // generous ceiling, well past the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

>>> split_datagram_reassembly_table_top.f
rtl/sdrt_pkg.sv
rtl/sdrt_slot_map.sv
rtl/split_datagram_reassembly_table_top.sv
dv/tb_split_datagram_reassembly_table_top.sv
